// ===== sv/keyframe_curve_sampler_top_defines.svh =====
// assertion macros shared by the checker
`ifndef KEYFRAME_CURVE_SAMPLER_TOP_DEFINES_SVH
`define KEYFRAME_CURVE_SAMPLER_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define KCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define KCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/kcs_pkg.sv =====
// ------------------------------------------------------------------
// kcs_pkg
// shared types and constants of the keyframe curve sampler
// ------------------------------------------------------------------
package kcs_pkg;
    localparam int MAX_CURVES  = 16;
    localparam int MAX_KEYS    = 64;
    localparam int CURVE_W     = 4;
    localparam int SLOT_W      = 6;
    localparam int ADDR_W      = CURVE_W + SLOT_W;
    localparam int COUNT_W     = 7;
    localparam int FRAC_W      = 16;

    typedef enum logic [1:0] {
        CMD_WRITE_KEY = 2'd0,
        CMD_SET_COUNT = 2'd1,
        CMD_SAMPLE    = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    // divider control between sequencer and divider
    typedef struct packed {
        logic        go;
        logic [32:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } div_rsp_t;
endpackage

// ===== sv/kcs_divider.sv =====
// ------------------------------------------------------------------
// kcs_divider
// restoring divider, one quotient bit per cycle, 17-bit quotient
// ------------------------------------------------------------------
module kcs_divider
    import kcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // numerator is diff<<16, quotient beyond 17 bits saturates anyway
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [32:0] num_reg, num_next;
    logic [16:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [33:0] trial;
    logic [34:0] diff;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[32:0], num_reg[32]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        if (req.go)
        begin
            // quotient of (a<<16)/b: preload rem with (a<<16)>>17, shift the low 17 bits in
            rem_next  = {2'b00, req.num[32:1]};
            num_next  = {req.num[0], 32'd0};
            den_next  = req.den;
            quo_next  = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
            // saturate when (a<<16)>>17 already reaches b: quotient >= 2^17
            if ({1'b0, req.num[32:1]} >= req.den)
            begin
                quo_next  = '1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[31:0], 1'b0};
            if (!diff[34])
            begin
                rem_next = diff[33:0];
                quo_next = {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// ===== sv/keyframe_curve_sampler_top.sv =====
// keyframe curve sampler: write key and set count finish at the accepting edge, busy stays low.
// a sample skips curves without keys; a curve with keys is clamped to its first or last key
// value outside the keys, else an upper-bound search (up to 7 probes) and the serial divider
// (used when span and offset are both positive) give the interpolated value. a new sample is
// taken only when idle. results lag one curve; the last shows in the first idle cycle, no stall.
// reset clears key counts and the sequencer; key stores are not cleared.
// ------------------------------------------------------------------
// keyframe_curve_sampler_top
// piecewise linear keyframe interpolation with a shared serial divider
// ------------------------------------------------------------------
module keyframe_curve_sampler_top
    import kcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [3:0]         curve_sel,
    input  logic [5:0]         key_slot,
    input  logic signed [31:0] key_time,
    input  logic signed [31:0] key_val,
    input  logic [6:0]         key_total,
    input  logic signed [31:0] sample_time,
    output logic               result_valid,
    output logic [3:0]         curve_id,
    output logic signed [31:0] sampled_value,
    output logic               last_of_run
);
    typedef enum logic [3:0] {
        S_IDLE, S_NEXT, S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST, S_PROBE, S_PROBE_CHK,
        S_RD_PAIR, S_GET_PAIR, S_DIV, S_MUL, S_ADD, S_EMIT
    } state_t;

    // key memories
    logic [31:0] time_mem  [MAX_CURVES*MAX_KEYS];
    logic [31:0] value_mem [MAX_CURVES*MAX_KEYS];
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0] t_rd_reg, v_rd_reg;
    logic [COUNT_W-1:0] count_reg [MAX_CURVES];

    state_t state_reg, state_next;
    logic signed [31:0] t_reg, t_next;
    logic [CURVE_W:0]   cur_reg, cur_next;
    logic [COUNT_W-1:0] first_reg, first_next, cnt_reg, cnt_next;
    logic signed [31:0] t0_reg, t0_next, v0_reg, v0_next, v1_reg, v1_next;
    logic signed [32:0] span_reg, span_next;
    logic signed [32:0] dlt_reg, dlt_next;
    logic [16:0] frac_reg, frac_next;
    logic signed [49:0] prod_reg, prod_next;
    logic signed [31:0] res_reg, res_next;
    logic have_reg, have_next;
    logic rv_reg, rv_next, last_reg, last_next;
    logic [3:0] id_reg, id_next;
    logic [31:0] out_reg, out_next;
    logic pair_reg, pair_next;
    // pending result buffer
    logic [3:0]  pid_reg, pid_next;
    logic [31:0] pval_reg, pval_next;
    div_req_t dreq;
    div_rsp_t drsp;

    logic [COUNT_W-1:0] n_cur, mid, step;
    logic [CURVE_W-1:0] cidx;

    assign cidx  = cur_reg[CURVE_W-1:0];
    assign n_cur = count_reg[cidx];
    assign step  = cnt_reg >> 1;
    assign mid   = first_reg + step;

    kcs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (!busy && start && cmd_t'(command) == CMD_WRITE_KEY)
        begin
            time_mem[{curve_sel, key_slot}]  <= key_time;
            value_mem[{curve_sel, key_slot}] <= key_val;
        end
        t_rd_reg <= time_mem[rd_addr];
        v_rd_reg <= value_mem[rd_addr];
    end

    // key counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CURVES; i++)
                count_reg[i] <= '0;
        end
        else if (!busy && start && cmd_t'(command) == CMD_SET_COUNT)
        begin
            count_reg[curve_sel] <= (key_total > COUNT_W'(MAX_KEYS)) ?
                COUNT_W'(MAX_KEYS) : key_total;
        end
    end

    // read address select
    always_comb
    begin
        case (state_reg)
            S_CHK_FIRST: rd_addr = {cidx, SLOT_W'(n_cur - 7'd1)};
            S_PROBE:     rd_addr = {cidx, SLOT_W'(mid)};
            S_RD_PAIR:   rd_addr = {cidx, SLOT_W'(first_reg - 7'd1)};
            S_GET_PAIR:  rd_addr = {cidx, SLOT_W'(first_reg)};
            default:     rd_addr = {cidx, SLOT_W'(0)};
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        t_next       = t_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        cnt_next     = cnt_reg;
        t0_next      = t0_reg;
        v0_next      = v0_reg;
        v1_next      = v1_reg;
        span_next    = span_reg;
        dlt_next     = dlt_reg;
        frac_next    = frac_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        have_next    = have_reg;
        rv_next      = 1'b0;
        last_next    = 1'b0;
        id_next      = id_reg;
        out_next     = out_reg;
        pid_next     = pid_reg;
        pval_next    = pval_reg;
        pair_next    = pair_reg;
        dreq.go      = 1'b0;
        dreq.num     = dlt_reg;
        dreq.den     = span_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && cmd_t'(command) == CMD_SAMPLE)
                begin
                    t_next     = sample_time;
                    cur_next   = '0;
                    have_next  = 1'b0;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                // walk to the next curve with keys
                if (cur_reg[CURVE_W])
                begin
                    if (have_reg)
                    begin
                        rv_next   = 1'b1;
                        last_next = 1'b1;
                        id_next   = pid_reg;
                        out_next  = pval_reg;
                    end
                    state_next = S_IDLE;
                end
                else if (n_cur == '0)
                    cur_next = cur_reg + 1'b1;
                else
                    state_next = S_RD_FIRST;
            end
            S_RD_FIRST:  state_next = S_CHK_FIRST;
            S_CHK_FIRST:
            begin
                if (t_reg <= $signed(t_rd_reg))
                begin
                    res_next   = v_rd_reg;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_CHK_LAST;
            end
            S_CHK_LAST:
            begin
                if (t_reg >= $signed(t_rd_reg))
                begin
                    res_next   = v_rd_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    first_next = '0;
                    cnt_next   = n_cur;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (cnt_reg == '0)
                    state_next = S_RD_PAIR;
                else
                    state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                // one upper-bound search step
                if (!(t_reg < $signed(t_rd_reg)))
                begin
                    first_next = mid + 7'd1;
                    cnt_next   = cnt_reg - step - 7'd1;
                end
                else
                    cnt_next = step;
                state_next = S_PROBE;
            end
            S_RD_PAIR:
            begin
                pair_next  = 1'b0;
                state_next = S_GET_PAIR;
            end
            S_GET_PAIR:
            begin
                // first read returns key upper-1, second returns key upper
                if (!pair_reg)
                begin
                    t0_next   = t_rd_reg;
                    v0_next   = v_rd_reg;
                    pair_next = 1'b1;
                end
                else
                begin
                    v1_next   = v_rd_reg;
                    span_next = 33'($signed(t_rd_reg)) - 33'(t0_reg);
                    dlt_next  = 33'(t_reg) - 33'(t0_reg);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                pair_next = 1'b0;
                if (span_reg <= 0 || dlt_reg <= 0)
                begin
                    frac_next  = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    dreq.go    = 1'b1;
                    state_next = S_MUL;
                    frac_next  = 17'h1ffff;
                end
            end
            S_MUL:
            begin
                // wait for divider when it was started
                if (frac_reg == 17'h1ffff && !drsp.done)
                    state_next = S_MUL;
                else
                begin
                    if (frac_reg == 17'h1ffff)
                        frac_next = (drsp.quo > 17'd65535) ? 17'd65535 : drsp.quo;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (!pair_reg)
                begin
                    prod_next = (33'(v1_reg) - 33'(v0_reg)) * $signed({1'b0, frac_reg});
                    pair_next = 1'b1;
                end
                else
                begin
                    res_next   = v0_reg + 32'(prod_reg >>> FRAC_W);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold one result back so the final one can carry last
                if (have_reg)
                begin
                    rv_next  = 1'b1;
                    id_next  = pid_reg;
                    out_next = pval_reg;
                end
                pid_next   = cidx;
                pval_next  = res_reg;
                have_next  = 1'b1;
                cur_next   = cur_reg + 1'b1;
                state_next = S_NEXT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            last_reg  <= 1'b0;
            have_reg  <= 1'b0;
            pair_reg  <= 1'b0;
            t_reg     <= '0;
            cur_reg   <= '0;
            first_reg <= '0;
            cnt_reg   <= '0;
            t0_reg    <= '0;
            v0_reg    <= '0;
            v1_reg    <= '0;
            span_reg  <= '0;
            dlt_reg   <= '0;
            frac_reg  <= '0;
            prod_reg  <= '0;
            res_reg   <= '0;
            id_reg    <= '0;
            out_reg   <= '0;
            pid_reg   <= '0;
            pval_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            last_reg  <= last_next;
            have_reg  <= have_next;
            pair_reg  <= pair_next;
            t_reg     <= t_next;
            cur_reg   <= cur_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
            t0_reg    <= t0_next;
            v0_reg    <= v0_next;
            v1_reg    <= v1_next;
            span_reg  <= span_next;
            dlt_reg   <= dlt_next;
            frac_reg  <= frac_next;
            prod_reg  <= prod_next;
            res_reg   <= res_next;
            id_reg    <= id_next;
            out_reg   <= out_next;
            pid_reg   <= pid_next;
            pval_reg  <= pval_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = rv_reg;
    assign curve_id      = id_reg;
    assign sampled_value = out_reg;
    assign last_of_run   = last_reg;
endmodule

// ===== sv/kcs_checker.sv =====
// ------------------------------------------------------------------
// kcs_checker
// port-level checks of the keyframe curve sampler
// ------------------------------------------------------------------
`include "keyframe_curve_sampler_top_defines.svh"
module kcs_checker
    import kcs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] command,
    input logic       result_valid,
    input logic       last_of_run
);
    // last marker only on a result transfer
    `KCS_ASSERT_IMP(a_last_valid, clk, rst_n, last_of_run, result_valid)
    // no result while idle and not finishing
    `KCS_ASSERT_IMP(a_res_busy, clk, rst_n, result_valid && !last_of_run, busy)
    // an accepted sample makes the block busy
    `KCS_ASSERT_NEXT(a_sample_busy, clk, rst_n,
        start && !busy && command == CMD_SAMPLE, busy)
    // any command other than sample leaves the block free
    `KCS_ASSERT_NEXT(a_cfg_idle, clk, rst_n,
        start && !busy && command != CMD_SAMPLE, !busy)
endmodule

bind keyframe_curve_sampler_top kcs_checker u_kcs_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
    .result_valid(result_valid), .last_of_run(last_of_run)
);
